// File: design/mcol_pkg.sv
// Shared constants, types and controller/datapath interface structs for the open list.
package mcol_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W   = 2;
	localparam int ID_W   = 16;
	localparam int COST_W = 24;
	localparam int ST_W   = 2;
	localparam int OCC_W  = 7;

	localparam int S_DATA_W   = 40;
	localparam int M_FIELDS_W = ST_W + 1 + ID_W + COST_W + OCC_W;
	localparam int M_DATA_W   = 56;
	localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD      = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_POP      = 2'd3
	} op_t;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [COST_W-1:0] cost;
	} slot_t;

	typedef struct packed {
		logic load;       // latch the input transaction
		logic add;        // append, or flag a drop when full
		logic clr;        // empty the list
		logic scan_init;  // rewind scan index, clear hit/min
		logic rd_en;      // read slot at scan index, advance index
		logic cmp;        // fold read data into hit/min
		logic shift_init; // index to one past the minimum
		logic shift_wr;   // write read data one slot down
		logic dec_fill;   // drop one entry from the count
		logic res_load;   // load the output register
	} mcol_cmd_t;

	typedef struct packed {
		op_t  op;
		logic fill_zero;
		logic idx_end;
		logic res_busy;
	} mcol_sts_t;

endpackage

// File: design/mcol_dp.sv
// Datapath: slot memory, fill count, scan index, min/hit tracking and output register.
module mcol_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcol_pkg::mcol_cmd_t            cmd,
	output mcol_pkg::mcol_sts_t            sts,
	input  logic [mcol_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [mcol_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mcol_pkg::M_DATA_W-1:0]  m_tdata
);

	mcol_pkg::slot_t mem [mcol_pkg::CAPACITY];

	logic [mcol_pkg::CNT_W-1:0]  fill_q;
	logic [mcol_pkg::CNT_W-1:0]  idx_q;
	logic                        rd_vld_s1;
	logic [mcol_pkg::IDX_W-1:0]  rd_idx_s1;
	mcol_pkg::slot_t             rd_slot_s1;
	mcol_pkg::op_t               op_q;
	logic [mcol_pkg::ID_W-1:0]   id_q;
	logic [mcol_pkg::COST_W-1:0] cost_q;
	logic                        drop_q;
	logic                        hit_q;
	logic                        have_best_q;
	mcol_pkg::slot_t             best_q;
	logic [mcol_pkg::IDX_W-1:0]  best_idx_q;

	logic                        full;
	logic [mcol_pkg::ST_W-1:0]   res_status;
	logic                        res_found;
	mcol_pkg::slot_t             res_slot;

	assign full = (fill_q == mcol_pkg::CNT_W'(mcol_pkg::CAPACITY));

	assign sts.op        = op_q;
	assign sts.fill_zero = (fill_q == '0);
	assign sts.idx_end   = (idx_q == fill_q);
	assign sts.res_busy  = m_tvalid & ~m_tready;

	always_comb begin
		res_status = mcol_pkg::ST_OK;
		res_found  = 1'b0;
		res_slot   = '0;
		unique case (op_q)
			mcol_pkg::OP_ADD: begin
				if (drop_q) res_status = mcol_pkg::ST_FULL;
			end
			mcol_pkg::OP_CONTAINS: begin
				res_found = hit_q;
			end
			mcol_pkg::OP_POP: begin
				if (have_best_q) begin
					res_found = 1'b1;
					res_slot  = best_q;
				end else begin
					res_status = mcol_pkg::ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			rd_vld_s1 <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				fill_q <= '0;
			end else if (cmd.add && !full) begin
				fill_q <= fill_q + mcol_pkg::CNT_W'(1);
			end else if (cmd.dec_fill) begin
				fill_q <= fill_q - mcol_pkg::CNT_W'(1);
			end
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.res_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// payload and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= mcol_pkg::op_t'(s_tuser);
			id_q   <= s_tdata[mcol_pkg::ID_W-1:0];
			cost_q <= s_tdata[mcol_pkg::ID_W +: mcol_pkg::COST_W];
		end
		if (cmd.add) drop_q <= full;

		if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.shift_init) begin
			idx_q <= mcol_pkg::CNT_W'(best_idx_q) + mcol_pkg::CNT_W'(1);
		end else if (cmd.rd_en) begin
			idx_q <= idx_q + mcol_pkg::CNT_W'(1);
		end
		if (cmd.rd_en) rd_idx_s1 <= idx_q[mcol_pkg::IDX_W-1:0];

		if (cmd.scan_init) begin
			hit_q       <= 1'b0;
			have_best_q <= 1'b0;
		end else if (cmd.cmp && rd_vld_s1) begin
			if (rd_slot_s1.id == id_q) hit_q <= 1'b1;
			// strict less-than keeps the earliest slot on a cost tie
			if (!have_best_q || (rd_slot_s1.cost < best_q.cost)) begin
				best_q      <= rd_slot_s1;
				best_idx_q  <= rd_idx_s1;
				have_best_q <= 1'b1;
			end
		end

		if (cmd.res_load) begin
			m_tdata <= {{mcol_pkg::M_PAD_W{1'b0}},
				mcol_pkg::OCC_W'(fill_q),
				res_slot.cost, res_slot.id, res_found, res_status};
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.add && !full) begin
			mem[fill_q[mcol_pkg::IDX_W-1:0]] <= '{id: id_q, cost: cost_q};
		end else if (cmd.shift_wr && rd_vld_s1) begin
			mem[rd_idx_s1 - mcol_pkg::IDX_W'(1)] <= rd_slot_s1;
		end
		if (cmd.rd_en) rd_slot_s1 <= mem[idx_q[mcol_pkg::IDX_W-1:0]];
	end

endmodule

// File: design/mcol_ctrl.sv
// Controller: sequences decode, scan, shift-down and result hand-off.
module mcol_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  mcol_pkg::mcol_sts_t  sts,
	output mcol_pkg::mcol_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT_INIT,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					mcol_pkg::OP_CLEAR: begin
						cmd.clr   = 1'b1;
						state_nxt = S_FINISH;
					end
					mcol_pkg::OP_ADD: begin
						cmd.add   = 1'b1;
						state_nxt = S_FINISH;
					end
					default: begin
						cmd.scan_init = 1'b1;
						state_nxt     = S_SCAN;
					end
				endcase
			end
			S_SCAN: begin
				cmd.cmp   = 1'b1;
				cmd.rd_en = ~sts.idx_end;
				if (sts.idx_end) begin
					if (sts.op == mcol_pkg::OP_POP && !sts.fill_zero) begin
						state_nxt = S_SHIFT_INIT;
					end else begin
						state_nxt = S_FINISH;
					end
				end
			end
			S_SHIFT_INIT: begin
				cmd.shift_init = 1'b1;
				state_nxt      = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				cmd.rd_en    = ~sts.idx_end;
				if (sts.idx_end) begin
					cmd.dec_fill = 1'b1;
					state_nxt    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.res_busy) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: design/min_cost_open_list.sv
// Top level of the min-cost open list: controller plus datapath.
//
// Open list for a path search: an unsorted array of up to 64 (id, cost)
// entries kept in insertion order. One input transaction carries one
// operation on s_tuser (clear, add, contains, pop-minimum) with the id and
// cost on s_tdata; each operation returns exactly one result transaction
// on m_tdata with status, found, popped id/cost and the occupancy after it.
//
// Steps per operation: clear and add decode and then load the result;
// contains scans the filled slots, one slot read per cycle, then loads the
// result; pop scans for the minimum at slot k, shifts the slots above k
// one place down, drops the count and loads the result.
// The single read port of the slot memory paces both passes: the scan
// reads one slot per cycle, and the shift-down reads one slot and writes
// it one place lower per cycle. One operation is in flight at a time.
//
// Reset empties the list (fill count to zero); the slot memory is not
// cleared since only slots below the fill count are ever read.
// The result sits in an output register: the next transaction is accepted
// while an earlier result waits, and the block holds at its finish step
// until m_tready frees the register.
module min_cost_open_list (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, low bit up: entry_id[15:0], entry_cost[39:16]
	input  logic [mcol_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: op[1:0]
	input  logic [mcol_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, low bit up: status[1:0], found[2], out_id[18:3],
	// out_cost[42:19], occupancy[49:43], zero pad[55:50]
	output logic [mcol_pkg::M_DATA_W-1:0] m_tdata
);

	mcol_pkg::mcol_cmd_t cmd;
	mcol_pkg::mcol_sts_t sts;

	mcol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcol_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: design/mcol_chk.sv
// Port-level checker for the open list, bound to the top level.
module mcol_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [mcol_pkg::S_DATA_W-1:0] s_tdata,
	input logic [mcol_pkg::OP_W-1:0]     s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mcol_pkg::M_DATA_W-1:0] m_tdata
);

	logic [mcol_pkg::ST_W-1:0]  st;
	logic                       fnd;
	logic [mcol_pkg::OCC_W-1:0] occ;

	assign st  = m_tdata[mcol_pkg::ST_W-1:0];
	assign fnd = m_tdata[mcol_pkg::ST_W];
	assign occ = m_tdata[mcol_pkg::M_FIELDS_W-1 -: mcol_pkg::OCC_W];

	// a waiting input transaction holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input changed while waiting");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ <= mcol_pkg::OCC_W'(mcol_pkg::CAPACITY))
		else $error("occupancy above capacity");

	// a dropped add only happens on a full list
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == mcol_pkg::ST_FULL
		|-> occ == mcol_pkg::OCC_W'(mcol_pkg::CAPACITY) && !fnd)
		else $error("full status with room left");

	// an empty pop leaves the list empty and returns nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st == mcol_pkg::ST_EMPTY
		|-> occ == '0 && !fnd && m_tdata[mcol_pkg::M_FIELDS_W-mcol_pkg::OCC_W-1:3] == '0)
		else $error("empty pop with entries or data");

endmodule

bind min_cost_open_list mcol_chk u_mcol_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
